[rtl/scsq_pkg.sv]
// Shared types, codes and the result decoder for the SPI NOR command sequencer.
// Used by every module of the block; depends on nothing.
package scsq_pkg;

  localparam int ADDR_IN_W        = 24;
  localparam int LEN_W            = 16;
  localparam int QUEUE_DEPTH      = 4;
  localparam int PAGE_BYTES_DEF   = 256;
  localparam int ADDRESS_BITS_DEF = 24;
  localparam int BUSY_BIT         = 0;

  typedef logic [2:0]           cmd_t;
  typedef logic [2:0]           kind_t;
  typedef logic [2:0]           step_t;
  typedef logic [2:0]           jtype_t;
  typedef logic [7:0]           byte_t;
  typedef logic [ADDR_IN_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]     len_t;

  localparam cmd_t CMD_READ     = 3'd0;
  localparam cmd_t CMD_WRITE    = 3'd1;
  localparam cmd_t CMD_ERASE    = 3'd2;
  localparam cmd_t CMD_STATUS   = 3'd3;
  localparam cmd_t CMD_RD_REPLY = 3'd4;

  localparam kind_t K_SEND    = 3'd0;
  localparam kind_t K_RECV    = 3'd1;
  localparam kind_t K_HOST    = 3'd2;
  localparam kind_t K_DONE    = 3'd3;
  localparam kind_t K_REFUSED = 3'd4;
  localparam kind_t K_ERROR   = 3'd5;

  localparam byte_t FL_WREN = 8'h06;
  localparam byte_t FL_PP   = 8'h02;
  localparam byte_t FL_READ = 8'h03;
  localparam byte_t FL_SE   = 8'h20;
  localparam byte_t FL_RDSR = 8'h05;

  localparam jtype_t J_SINGLE = 3'd0;
  localparam jtype_t J_READ   = 3'd1;
  localparam jtype_t J_WRITE  = 3'd2;
  localparam jtype_t J_ERASE  = 3'd3;
  localparam jtype_t J_HOST   = 3'd4;

  typedef struct packed {
    jtype_t jtype;
    kind_t  kind;
    step_t  first;
    step_t  final_step;
    addr_t  addr;
    byte_t  data;
    logic   fend;
    logic   finish;
  } job_t;

  typedef struct packed {
    kind_t kind;
    byte_t value;
    logic  frame_end;
  } res_t;

  // Result produced by one step of a job.
  function automatic res_t result_at(job_t j, step_t s);
    res_t r;
    r.kind      = K_SEND;
    r.value     = '0;
    r.frame_end = 1'b0;
    unique case (j.jtype)
      J_READ: begin
        unique case (s)
          3'd1: r.value = FL_READ;
          3'd2: r.value = j.addr[23:16];
          3'd3: r.value = j.addr[15:8];
          3'd4: r.value = j.addr[7:0];
          default: begin
            r.kind      = K_RECV;
            r.frame_end = j.fend;
          end
        endcase
      end
      J_WRITE: begin
        unique case (s)
          3'd0: begin
            r.value     = FL_WREN;
            r.frame_end = 1'b1;
          end
          3'd1: r.value = FL_PP;
          3'd2: r.value = j.addr[23:16];
          3'd3: r.value = j.addr[15:8];
          3'd4: r.value = j.addr[7:0];
          3'd5: begin
            r.value     = j.data;
            r.frame_end = j.fend;
          end
          3'd6: r.value = FL_RDSR;
          default: begin
            r.kind      = K_RECV;
            r.frame_end = 1'b1;
          end
        endcase
      end
      J_ERASE: begin
        unique case (s)
          3'd0: begin
            r.value     = FL_WREN;
            r.frame_end = 1'b1;
          end
          3'd1: r.value = FL_SE;
          3'd2: r.value = j.addr[23:16];
          3'd3: r.value = j.addr[15:8];
          3'd4: begin
            r.value     = j.addr[7:0];
            r.frame_end = 1'b1;
          end
          3'd5: r.value = FL_RDSR;
          default: begin
            r.kind      = K_RECV;
            r.frame_end = 1'b1;
          end
        endcase
      end
      J_HOST: begin
        if (s == 3'd0) begin
          r.kind  = K_HOST;
          r.value = j.data;
        end else if (j.finish) begin
          r.kind = K_DONE;
        end else begin
          r.kind      = K_RECV;
          r.frame_end = j.fend;
        end
      end
      default: r.kind = j.kind;
    endcase
    return r;
  endfunction

endpackage

[rtl/scsq_if.sv]
// Handshake channels of the SPI NOR command sequencer: host items in, results out.
// Depends on scsq_pkg for the field types.
interface scsq_in_if;
  logic                  valid;
  logic                  ready;
  scsq_pkg::cmd_t        command;
  scsq_pkg::addr_t       address;
  scsq_pkg::len_t        read_length;
  scsq_pkg::byte_t       data_byte;
  logic                  final_byte;
  logic                  bus_granted;

  modport source (output valid, command, address, read_length, data_byte, final_byte,
                  bus_granted, input ready);
  modport sink (input valid, command, address, read_length, data_byte, final_byte,
                bus_granted, output ready);
endinterface

interface scsq_out_if;
  logic            valid;
  logic            ready;
  scsq_pkg::kind_t kind;
  scsq_pkg::byte_t byte_value;
  logic            frame_end;
  logic            last;

  modport source (output valid, kind, byte_value, frame_end, last, input ready);
  modport sink (input valid, kind, byte_value, frame_end, last, output ready);
endinterface

[rtl/scsq_pgmod.sv]
// Page offset unit: the start address modulo the page size.
// A power-of-two page is a mask; any other size uses reciprocal multiplication,
// registering the quotient and then the remainder. Uses scsq_pkg.
module scsq_pgmod #(
  parameter int PAGE_BYTES = scsq_pkg::PAGE_BYTES_DEF,
  parameter int ADDR_W     = scsq_pkg::ADDRESS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req,
  input  logic                          clr,
  input  logic [ADDR_W-1:0]             addr,
  output logic                          ok,
  output logic [$clog2(PAGE_BYTES)-1:0] rem
);

  localparam int PW   = $clog2(PAGE_BYTES);
  localparam int QW   = ADDR_W - PW + 1;
  localparam int SH   = ADDR_W + PW;
  localparam int MW   = ADDR_W + 1;
  localparam int PRW  = 2 * ADDR_W + 1;
  localparam bit POW2 = (PAGE_BYTES & (PAGE_BYTES - 1)) == 0;
  localparam logic [PW:0] PAGE_V = (PW + 1)'(PAGE_BYTES);
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

  logic              run_r;
  logic              ok_r;
  logic [QW-1:0]     quo_r;
  logic [PW-1:0]     rem_r;
  logic [PRW-1:0]    prod;
  logic [ADDR_W-1:0] back_prod;
  logic [ADDR_W-1:0] diff;

  assign prod      = PRW'(addr) * PRW'(RECIP);
  assign back_prod = ADDR_W'(quo_r) * ADDR_W'(PAGE_BYTES);
  assign diff      = addr - back_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      ok_r  <= 1'b0;
    end else if (clr) begin
      run_r <= 1'b0;
      ok_r  <= 1'b0;
    end else if (run_r) begin
      run_r <= 1'b0;
      ok_r  <= 1'b1;
    end else if (req && !ok_r) begin
      run_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (run_r) begin
      rem_r <= diff[PW-1:0];
    end else if (req && !ok_r) begin
      quo_r <= prod[SH +: QW];
    end
  end

  assign ok  = POW2 ? 1'b1 : ok_r;
  assign rem = POW2 ? addr[PW-1:0] : rem_r;

  a_rem_in_page: assert property (@(posedge clk) disable iff (!rst_n)
    ok_r |-> ({1'b0, rem_r} < PAGE_V))
    else $error("page offset out of range");

endmodule

[rtl/scsq_front.sv]
// Front end: accepts host items, checks them against the operation state and turns each
// into a job, save a not-busy mid-write status. Uses scsq_pkg, scsq_in_if and scsq_pgmod.
module scsq_front #(
  parameter int PAGE_BYTES = scsq_pkg::PAGE_BYTES_DEF,
  parameter int ADDR_W     = scsq_pkg::ADDRESS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  scsq_in_if.sink                       in_ch,
  input  logic                          q_full,
  output logic                          q_push,
  output scsq_pkg::job_t                q_job,
  output logic                          mod_req,
  output logic                          mod_clr,
  input  logic                          mod_ok,
  input  logic [$clog2(PAGE_BYTES)-1:0] mod_rem
);

  localparam int PW = $clog2(PAGE_BYTES);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_READ     = 4'd1;
  localparam logic [3:0] PH_WRITE    = 4'd2;
  localparam logic [3:0] PH_POLL_MID = 4'd3;
  localparam logic [3:0] PH_POLL_END = 4'd4;

  localparam logic [1:0] OPN_NONE  = 2'd0;
  localparam logic [1:0] OPN_READ  = 2'd1;
  localparam logic [1:0] OPN_WRITE = 2'd2;
  localparam logic [1:0] OPN_ERASE = 2'd3;

  logic [3:0]          phase_r, phase_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [ADDR_W-1:0]   cur_r, cur_nxt;
  scsq_pkg::len_t      rem_r, rem_nxt;
  logic                pfo_r, pfo_nxt;
  logic [PW-1:0]       off_r, off_nxt;

  logic                accept;
  logic                idle;
  logic                has_res;
  logic [ADDR_W-1:0]   addr_m;
  logic [ADDR_W-1:0]   wb_cur;
  logic [ADDR_W-1:0]   wb_next;
  logic [PW-1:0]       wb_off;
  logic [PW-1:0]       wb_inc;
  logic [PW-1:0]       wb_noff;
  logic                wb_open;
  logic                wb_close;
  scsq_pkg::len_t      rem_dec;
  scsq_pkg::job_t      job;

  assign idle    = (phase_r == PH_IDLE);
  assign addr_m  = in_ch.address[ADDR_W-1:0];
  assign mod_req = in_ch.valid && idle && (in_ch.command == scsq_pkg::CMD_WRITE) &&
                   in_ch.bus_granted;
  assign in_ch.ready = !q_full && (!mod_req || mod_ok);
  assign accept  = in_ch.valid && in_ch.ready;
  assign mod_clr = accept;

  assign wb_cur   = idle ? addr_m : cur_r;
  assign wb_off   = idle ? mod_rem : off_r;
  assign wb_open  = idle ? 1'b0 : pfo_r;
  assign wb_next  = wb_cur + ADDR_W'(1);
  assign wb_inc   = (wb_off == PW'(PAGE_BYTES - 1)) ? '0 : wb_off + PW'(1);
  assign wb_noff  = (wb_next == '0) ? '0 : wb_inc;
  assign wb_close = in_ch.final_byte || (wb_noff == '0);
  assign rem_dec  = rem_r - scsq_pkg::LEN_W'(1);

  always_comb begin
    phase_nxt      = phase_r;
    op_nxt         = op_r;
    cur_nxt        = cur_r;
    rem_nxt        = rem_r;
    pfo_nxt        = pfo_r;
    off_nxt        = off_r;
    has_res        = 1'b1;
    job.jtype      = scsq_pkg::J_SINGLE;
    job.kind       = scsq_pkg::K_ERROR;
    job.first      = 3'd0;
    job.final_step = 3'd0;
    job.addr       = scsq_pkg::addr_t'(wb_cur);
    job.data       = in_ch.data_byte;
    job.fend       = 1'b0;
    job.finish     = 1'b0;
    priority if (idle && in_ch.command == scsq_pkg::CMD_READ && in_ch.read_length == '0) begin
      job.kind = scsq_pkg::K_DONE;
    end else if (idle && in_ch.command <= scsq_pkg::CMD_ERASE) begin
      if (!in_ch.bus_granted) begin
        job.kind = scsq_pkg::K_REFUSED;
      end else if (in_ch.command == scsq_pkg::CMD_READ) begin
        cur_nxt        = addr_m;
        rem_nxt        = in_ch.read_length;
        op_nxt         = OPN_READ;
        phase_nxt      = PH_READ;
        job.jtype      = scsq_pkg::J_READ;
        job.first      = 3'd1;
        job.final_step = 3'd5;
        job.fend       = (in_ch.read_length == scsq_pkg::LEN_W'(1));
      end else if (in_ch.command == scsq_pkg::CMD_ERASE) begin
        cur_nxt        = addr_m;
        op_nxt         = OPN_ERASE;
        phase_nxt      = PH_POLL_END;
        job.jtype      = scsq_pkg::J_ERASE;
        job.final_step = 3'd6;
      end else begin
        op_nxt         = OPN_WRITE;
        cur_nxt        = wb_next;
        off_nxt        = wb_noff;
        pfo_nxt        = !wb_close;
        phase_nxt      = wb_close ? (in_ch.final_byte ? PH_POLL_END : PH_POLL_MID) : PH_WRITE;
        job.jtype      = scsq_pkg::J_WRITE;
        job.first      = 3'd0;
        job.final_step = wb_close ? 3'd7 : 3'd5;
        job.fend       = wb_close;
      end
    end else if (phase_r == PH_WRITE && in_ch.command == scsq_pkg::CMD_WRITE) begin
      cur_nxt        = wb_next;
      off_nxt        = wb_noff;
      pfo_nxt        = !wb_close;
      phase_nxt      = wb_close ? (in_ch.final_byte ? PH_POLL_END : PH_POLL_MID) : PH_WRITE;
      job.jtype      = scsq_pkg::J_WRITE;
      job.first      = wb_open ? 3'd5 : 3'd0;
      job.final_step = wb_close ? 3'd7 : 3'd5;
      job.fend       = wb_close;
    end else if (phase_r == PH_READ && in_ch.command == scsq_pkg::CMD_RD_REPLY) begin
      rem_nxt        = rem_dec;
      job.jtype      = scsq_pkg::J_HOST;
      job.final_step = 3'd1;
      if (rem_dec != '0) begin
        job.fend = (rem_dec == scsq_pkg::LEN_W'(1));
      end else begin
        job.finish = 1'b1;
        phase_nxt  = PH_IDLE;
        op_nxt     = OPN_NONE;
        pfo_nxt    = 1'b0;
      end
    end else if ((phase_r == PH_POLL_MID || phase_r == PH_POLL_END) &&
                 in_ch.command == scsq_pkg::CMD_STATUS) begin
      if (in_ch.data_byte[scsq_pkg::BUSY_BIT]) begin
        job.jtype      = scsq_pkg::J_WRITE;
        job.first      = 3'd6;
        job.final_step = 3'd7;
      end else if (phase_r == PH_POLL_END) begin
        job.kind  = scsq_pkg::K_DONE;
        phase_nxt = PH_IDLE;
        op_nxt    = OPN_NONE;
        pfo_nxt   = 1'b0;
        rem_nxt   = '0;
      end else begin
        has_res   = 1'b0;
        phase_nxt = PH_WRITE;
      end
    end else begin
      job.kind = scsq_pkg::K_ERROR;
    end
  end

  assign q_push = accept && has_res;
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= OPN_NONE;
      cur_r   <= '0;
      rem_r   <= '0;
      pfo_r   <= 1'b0;
      off_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      cur_r   <= cur_nxt;
      rem_r   <= rem_nxt;
      pfo_r   <= pfo_nxt;
      off_r   <= off_nxt;
    end
  end

  a_read_state: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READ) |-> (rem_r != '0 && op_r == OPN_READ))
    else $error("read phase without bytes to read");

  a_frame_in_write: assert property (@(posedge clk) disable iff (!rst_n)
    pfo_r |-> (phase_r == PH_WRITE && op_r == OPN_WRITE))
    else $error("page frame open outside a write");

endmodule

[rtl/scsq_fifo.sv]
// Job queue between the front and back ends of the SPI NOR command sequencer.
// Small register queue of scsq_pkg::job_t entries.
module scsq_fifo #(
  parameter int DEPTH = scsq_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scsq_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output scsq_pkg::job_t dout,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  scsq_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  assign wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
  assign rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_nxt;
      end
      if (pop) begin
        rd_r <= rd_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("job queue underflow");

endmodule

[rtl/scsq_back.sv]
// Back end: steps through each queued job; one result per cycle while
// out_ch is ready, via an output register. Uses scsq_pkg, scsq_out_if.
module scsq_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  scsq_pkg::job_t q_head,
  output logic           q_pop,
  scsq_out_if.source     out_ch
);

  scsq_pkg::job_t  job_r;
  scsq_pkg::step_t step_r;
  logic            busy_r;
  logic            out_valid_r;
  scsq_pkg::res_t  res_r;
  logic            last_r;

  scsq_pkg::res_t  res;
  logic            adv;
  logic            at_last;

  assign res     = scsq_pkg::result_at(job_r, step_r);
  assign at_last = (step_r == job_r.final_step);
  assign adv     = busy_r && (!out_valid_r || out_ch.ready);
  assign q_pop   = !q_empty && (!busy_r || (adv && at_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (adv && at_last) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r  <= q_head;
      step_r <= q_head.first;
    end else if (adv) begin
      step_r <= step_r + 3'd1;
    end
    if (adv) begin
      res_r  <= res;
      last_r <= at_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = res_r.kind;
  assign out_ch.byte_value = res_r.value;
  assign out_ch.frame_end  = res_r.frame_end;
  assign out_ch.last       = last_r;

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= job_r.final_step))
    else $error("job step ran past its last result");

endmodule

[rtl/spi_nor_flash_command_sequencer.sv]
// Top level of the SPI NOR flash command sequencer.
// Depends on scsq_pkg, scsq_if, scsq_pgmod, scsq_front, scsq_fifo and scsq_back.
//
// in_ch carries host items (start read, write byte, erase sector, status reply,
// read reply); out_ch carries results (SPI send byte, receive request, host read
// byte, done, refused, error). A transfer happens when valid and ready are high
// at a rising edge. Each item yields zero to eight results, the last one flagged.
// The front end classifies an item in the cycle it is taken and queues a job;
// the back end expands a job into one result per cycle while out_ch is ready,
// through an output register. A job passes the queue, the back end's job register
// and the output register before its first result appears. An item is taken
// every cycle while the queue has room; the back end sets the sustained rate.
// A write that starts from idle with a page size that is not a power of two
// waits while the page offset unit computes the start offset by a reciprocal
// multiplication, registering the quotient and then the remainder.
// Reset is synchronous: the block returns to idle with an empty queue and no
// pending result. When out_ch stalls, the output register holds its result,
// the queue fills, and in_ch ready falls once the queue is full.
module spi_nor_flash_command_sequencer #(
  parameter int PAGE_BYTES   = scsq_pkg::PAGE_BYTES_DEF,
  parameter int ADDRESS_BITS = scsq_pkg::ADDRESS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  scsq_in_if.sink    in_ch,
  scsq_out_if.source out_ch
);

  localparam int ADDR_W = (ADDRESS_BITS < scsq_pkg::ADDR_IN_W) ? ADDRESS_BITS
                                                               : scsq_pkg::ADDR_IN_W;
  localparam int PW     = $clog2(PAGE_BYTES);

  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  scsq_pkg::job_t q_job;
  scsq_pkg::job_t q_head;
  logic           mod_req;
  logic           mod_clr;
  logic           mod_ok;
  logic [PW-1:0]  mod_rem;

  scsq_pgmod #(
    .PAGE_BYTES (PAGE_BYTES),
    .ADDR_W     (ADDR_W)
  ) u_pgmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .clr   (mod_clr),
    .addr  (in_ch.address[ADDR_W-1:0]),
    .ok    (mod_ok),
    .rem   (mod_rem)
  );

  scsq_front #(
    .PAGE_BYTES (PAGE_BYTES),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_job),
    .mod_req (mod_req),
    .mod_clr (mod_clr),
    .mod_ok  (mod_ok),
    .mod_rem (mod_rem)
  );

  scsq_fifo #(
    .DEPTH (scsq_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  scsq_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
